FILE: design/tsca_pkg.sv
// Shared types and constants for the TSN stream cycle aligner.
// No dependencies; compile first.
package tsca_pkg;

    localparam int STREAMS = 4;
    localparam int NUM_IDS = 4;
    localparam int SLOT_W  = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    localparam int STAMP_W = 64;
    localparam int PKT_W   = 32;
    localparam int SEQ_W   = 16;
    localparam int CYC_W   = 32;
    localparam int CNT_W   = 32;
    localparam int STAT_W  = 2;

    localparam int DIV_STEPS = STAMP_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPUTE_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_ID_0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_ID_1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_ID_2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_ID_3    = 3'd5;

    localparam logic [CYC_W-1:0] CYCLE_TIME_RESET = 32'd1000000;

    localparam logic [STAT_W-1:0] ST_WAIT    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RELEASE = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROP    = 2'd2;
    localparam logic [STAT_W-1:0] ST_RXERR   = 2'd3;

    typedef struct packed {
        logic               frame_ok;
        logic [SEQ_W-1:0]   seq_id;
        logic [PKT_W-1:0]   pkt_id;
        logic [STAMP_W-1:0] tx_stamp;
        logic [STAMP_W-1:0] now_ns;
    } frame_beat_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [STAMP_W-1:0] compute_at;
        logic [STAMP_W-1:0] release_stamp;
        logic [PKT_W-1:0]   release_pkt;
        logic [CNT_W-1:0]   drop_count;
    } result_beat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: design/tsca_remdiv.sv
// Bit-serial restoring remainder unit: 64-bit dividend, 32-bit divisor.
// Depends on tsca_pkg. One dividend bit per cycle, remainder only.
module tsca_remdiv
    import tsca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [STAMP_W-1:0] dividend,
    input  logic [CYC_W-1:0]   divisor,
    output logic [CYC_W-1:0]   rem,
    output div_stat_t          stat
);

    logic [STAMP_W-1:0]   div_reg;
    logic [STAMP_W-1:0]   div_next;
    logic [CYC_W-1:0]     rem_reg;
    logic [CYC_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CYC_W:0]       trial;
    logic [CYC_W:0]       diff;

    // trial remainder: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, div_reg[STAMP_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (load)
        begin
            div_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            div_next = {div_reg[STAMP_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, divisor}) ? diff[CYC_W-1:0] : trial[CYC_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign rem       = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: design/tsn_stream_cycle_aligner_core.sv
// Top level of the TSN stream cycle aligner: sequencer, slot store, release scan.
// Depends on tsca_pkg and tsca_remdiv.
//
//  channel  | ports                              | beat taken when
//  ---------+------------------------------------+------------------------------
//  frame    | start, busy, frame                 | start high and busy low
//  result   | result_valid, result               | every cycle result_valid is high
//  config   | cfg_we, cfg_idx, cfg_data          | cfg_we high
//
// A good frame passes the 64-step bit-serial remainder unit, then the subtract,
// add, two alternative add and decision steps; a late frame is dropped there,
// and any other goes on to the threshold step and a scan of every stream slot.
// A frame with frame_ok low is answered in the next cycle.
// busy is low in the result cycle, so the next frame may start there.
// Reset (rst_n, async, active low) clears slots and counters, resets configuration.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module tsn_stream_cycle_aligner_core
    import tsca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  frame_beat_t           frame,
    output logic                  result_valid,
    output result_beat_t          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_SUB  = 4'd2;
    localparam logic [3:0] S_ADD  = 4'd3;
    localparam logic [3:0] S_ALT  = 4'd4;
    localparam logic [3:0] S_ALT2 = 4'd5;
    localparam logic [3:0] S_DEC  = 4'd6;
    localparam logic [3:0] S_THR  = 4'd7;
    localparam logic [3:0] S_SCAN = 4'd8;

    function automatic logic [STAMP_W-1:0] sat_add(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
        logic [STAMP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAMP_W] ? '1 : s[STAMP_W-1:0];
    endfunction

    // configuration
    logic [CYC_W-1:0] cycle_time_reg;
    logic [CYC_W-1:0] compute_offset_reg;
    logic [SEQ_W-1:0] stream_id_reg [NUM_IDS];
    logic [CYC_W-1:0] cyc;

    // control
    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic              done_reg;
    logic              done_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;

    // frame fields held for the whole item
    logic [SEQ_W-1:0]   seq_reg;
    logic [PKT_W-1:0]   pkt_reg;
    logic [STAMP_W-1:0] ts_reg;
    logic [STAMP_W-1:0] now_reg;

    // datapath
    logic [STAMP_W-1:0] prod_reg;
    logic [STAMP_W-1:0] prod_next;
    logic [STAMP_W-1:0] base_reg;
    logic [STAMP_W-1:0] base_next;
    logic [STAMP_W-1:0] alt_reg;
    logic [STAMP_W-1:0] alt_next;
    logic [STAMP_W-1:0] thresh_reg;
    logic [STAMP_W-1:0] thresh_next;
    logic [STAMP_W-1:0] min_reg;
    logic [STAMP_W-1:0] min_next;
    logic [PKT_W-1:0]   max_reg;
    logic [PKT_W-1:0]   max_next;
    logic               rel_reg;
    logic               rel_next;
    logic [STAMP_W:0]   thr_diff;
    logic [SLOT_W-1:0]  match_slot;

    // architectural state
    logic [STAMP_W-1:0] slot_stamp_reg [STREAMS];
    logic [STAMP_W-1:0] slot_stamp_next [STREAMS];
    logic [PKT_W-1:0]   slot_pkt_reg [STREAMS];
    logic [PKT_W-1:0]   slot_pkt_next [STREAMS];
    logic [STAMP_W-1:0] next_compute_reg;
    logic [STAMP_W-1:0] next_compute_next;
    logic [STAMP_W-1:0] out_stamp_reg;
    logic [STAMP_W-1:0] out_stamp_next;
    logic [PKT_W-1:0]   out_pkt_reg;
    logic [PKT_W-1:0]   out_pkt_next;
    logic [CNT_W-1:0]   drops_reg;
    logic [CNT_W-1:0]   drops_next;

    // remainder unit
    logic               accept;
    logic               div_load;
    logic [CYC_W-1:0]   rem;
    div_stat_t          div_stat;
    logic [STAMP_W-1:0] scan_stamp;
    logic [PKT_W-1:0]   scan_pkt;
    logic               scan_rel;
    logic [STAMP_W-1:0] scan_min;
    logic [PKT_W-1:0]   scan_max;

    // a zero cycle length behaves as 1
    assign cyc = (cycle_time_reg == '0) ? CYC_W'(1) : cycle_time_reg;

    assign accept   = start && !busy;
    assign div_load = accept && frame.frame_ok;

    tsca_remdiv u_remdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (frame.tx_stamp),
        .divisor  (cyc),
        .rem      (rem),
        .stat     (div_stat)
    );

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_time_reg     <= CYCLE_TIME_RESET;
            compute_offset_reg <= '0;
            for (int i = 0; i < NUM_IDS; i++)
                stream_id_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_CYCLE_TIME:     cycle_time_reg     <= cfg_data[CYC_W-1:0];
                REG_COMPUTE_OFFSET: compute_offset_reg <= cfg_data[CYC_W-1:0];
                REG_STREAM_ID_0:    stream_id_reg[0]   <= cfg_data[SEQ_W-1:0];
                REG_STREAM_ID_1:    stream_id_reg[1]   <= cfg_data[SEQ_W-1:0];
                REG_STREAM_ID_2:    stream_id_reg[2]   <= cfg_data[SEQ_W-1:0];
                REG_STREAM_ID_3:    stream_id_reg[3]   <= cfg_data[SEQ_W-1:0];
                default:            ;
            endcase
        end
    end

    // slot lookup; later matches override, unmatched ids land in slot 0
    always_comb
    begin
        match_slot = '0;
        for (int i = 0; i < STREAMS; i++)
            if (stream_id_reg[i] == seq_reg)
                match_slot = SLOT_W'(i);
    end

    // threshold = next_compute - cycle, floored at zero
    assign thr_diff = {1'b0, next_compute_reg} - {{(STAMP_W - CYC_W + 1){1'b0}}, cyc};

    // one slot per scan cycle
    assign scan_stamp = slot_stamp_reg[idx_reg];
    assign scan_pkt   = slot_pkt_reg[idx_reg];
    assign scan_rel   = rel_reg && (scan_stamp >= thresh_reg);
    assign scan_min   = (scan_stamp < min_reg) ? scan_stamp : min_reg;
    assign scan_max   = (scan_pkt > max_reg) ? scan_pkt : max_reg;

    always_comb
    begin
        state_next        = state_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        idx_next          = idx_reg;
        prod_next         = prod_reg;
        base_next         = base_reg;
        alt_next          = alt_reg;
        thresh_next       = thresh_reg;
        min_next          = min_reg;
        max_next          = max_reg;
        rel_next          = rel_reg;
        slot_stamp_next   = slot_stamp_reg;
        slot_pkt_next     = slot_pkt_reg;
        next_compute_next = next_compute_reg;
        out_stamp_next    = out_stamp_reg;
        out_pkt_next      = out_pkt_reg;
        drops_next        = drops_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (frame.frame_ok)
                        state_next = S_DIV;
                    else
                    begin
                        status_next = ST_RXERR;
                        done_next   = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_SUB;
            end
            S_SUB:
            begin
                // floor(ts / cycle) * cycle is ts minus the remainder
                prod_next  = ts_reg - {{(STAMP_W - CYC_W){1'b0}}, rem};
                state_next = S_ADD;
            end
            S_ADD:
            begin
                base_next  = sat_add(prod_reg, {{(STAMP_W - CYC_W){1'b0}}, compute_offset_reg});
                state_next = S_ALT;
            end
            S_ALT:
            begin
                alt_next   = sat_add(prod_reg, {{(STAMP_W - CYC_W){1'b0}}, cyc});
                state_next = S_ALT2;
            end
            S_ALT2:
            begin
                alt_next   = sat_add(alt_reg, {{(STAMP_W - CYC_W){1'b0}}, compute_offset_reg});
                state_next = S_DEC;
            end
            S_DEC:
            begin
                priority if (base_reg >= now_reg)
                begin
                    next_compute_next          = base_reg;
                    slot_stamp_next[match_slot] = ts_reg;
                    slot_pkt_next[match_slot]   = pkt_reg;
                    state_next                 = S_THR;
                end
                else if (compute_offset_reg <= rem)
                begin
                    next_compute_next          = alt_reg;
                    slot_stamp_next[match_slot] = ts_reg;
                    slot_pkt_next[match_slot]   = pkt_reg;
                    state_next                 = S_THR;
                end
                else
                begin
                    // late frame: count it, nothing else moves
                    drops_next  = drops_reg + 1'b1;
                    status_next = ST_DROP;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_THR:
            begin
                thresh_next = thr_diff[STAMP_W] ? '0 : thr_diff[STAMP_W-1:0];
                min_next    = '1;
                max_next    = '0;
                rel_next    = (slot_stamp_reg[0] != '0);
                idx_next    = '0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                rel_next = scan_rel;
                min_next = scan_min;
                max_next = scan_max;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_W'(STREAMS - 1))
                begin
                    out_stamp_next = scan_min;
                    out_pkt_next   = scan_max;
                    status_next    = scan_rel ? ST_RELEASE : ST_WAIT;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            done_reg         <= 1'b0;
            status_reg       <= ST_WAIT;
            idx_reg          <= '0;
            next_compute_reg <= '0;
            out_stamp_reg    <= '0;
            out_pkt_reg      <= '0;
            drops_reg        <= '0;
            for (int i = 0; i < STREAMS; i++)
            begin
                slot_stamp_reg[i] <= '0;
                slot_pkt_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            done_reg         <= done_next;
            status_reg       <= status_next;
            idx_reg          <= idx_next;
            next_compute_reg <= next_compute_next;
            out_stamp_reg    <= out_stamp_next;
            out_pkt_reg      <= out_pkt_next;
            drops_reg        <= drops_next;
            slot_stamp_reg   <= slot_stamp_next;
            slot_pkt_reg     <= slot_pkt_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            seq_reg <= frame.seq_id;
            pkt_reg <= frame.pkt_id;
            ts_reg  <= frame.tx_stamp;
            now_reg <= frame.now_ns;
        end
        prod_reg   <= prod_next;
        base_reg   <= base_next;
        alt_reg    <= alt_next;
        thresh_reg <= thresh_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        rel_reg    <= rel_next;
    end

    // result beat shows the state as left by the item
    assign busy                 = (state_reg != S_IDLE);
    assign result_valid         = done_reg;
    assign result.status        = status_reg;
    assign result.compute_at    = next_compute_reg;
    assign result.release_stamp = out_stamp_reg;
    assign result.release_pkt   = out_pkt_reg;
    assign result.drop_count    = drops_reg;

endmodule

FILE: design/tsca_checker.sv
// Port-level checks for the cycle aligner core, bound to the top level.
// Depends on tsca_pkg and tsn_stream_cycle_aligner_core.
module tsca_checker
    import tsca_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input frame_beat_t  frame,
    input logic         result_valid,
    input result_beat_t result
);

    // results only appear with the block idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result beat while busy");

    // a bad frame is answered in the next cycle with the rx error code
    a_rxerr_next: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !frame.frame_ok |=> result_valid && result.status == ST_RXERR)
        else $error("rx error beat missing");

    // every finished item produces a beat
    a_finish_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("item finished without a result beat");

    // a drop bumps the counter by exactly one
    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_DROP
            |-> result.drop_count == $past(result.drop_count) + 32'd1)
        else $error("drop counter did not advance by one");

endmodule

bind tsn_stream_cycle_aligner_core tsca_checker u_tsca_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .frame        (frame),
    .result_valid (result_valid),
    .result       (result)
);

FILE: bench/tsn_stream_cycle_aligner_core_test.sv
// Self-checking bench for tsn_stream_cycle_aligner_core: directed and random frames.
// Predicts every result beat from its own copy of slots and registers.
// Depends on tsca_pkg and the core RTL.
module tsn_stream_cycle_aligner_core_test;
    import tsca_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    logic                  busy;
    frame_beat_t           frame    = '0;
    logic                  result_valid;
    result_beat_t          result;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tsn_stream_cycle_aligner_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .frame        (frame),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and slot store.
    // Updated only from the monitor, at the rising edge.
    // ------------------------------------------------------------------
    logic [CYC_W-1:0]   cyc_len = CYCLE_TIME_RESET;
    logic [CYC_W-1:0]   cmp_ofs = '0;
    logic [SEQ_W-1:0]   slot_ids   [NUM_IDS];
    logic [STAMP_W-1:0] held_stamp [STREAMS];
    logic [PKT_W-1:0]   held_pkt   [STREAMS];
    logic [STAMP_W-1:0] sched_at   = '0;
    logic [STAMP_W-1:0] low_stamp  = '0;
    logic [PKT_W-1:0]   high_pkt   = '0;
    logic [CNT_W-1:0]   late_drops = '0;

    // Stimulus side: frames waiting to go out, and what the last setup wrote.
    frame_beat_t        frame_backlog [$];
    result_beat_t       pending_results [$];
    logic [CYC_W-1:0]   set_cycle;
    logic [CYC_W-1:0]   set_offset;
    logic [SEQ_W-1:0]   set_ids [NUM_IDS];

    int  mismatches = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    logic took = 1'b0;      // frame beat taken at the last rising edge

    initial begin
        for (int i = 0; i < NUM_IDS; i++) slot_ids[i] = '0;
        for (int i = 0; i < STREAMS; i++) begin
            held_stamp[i] = '0;
            held_pkt[i]   = '0;
        end
    end

    // Sum that clamps at all ones instead of wrapping.
    function automatic logic [STAMP_W-1:0] add_clamp(logic [STAMP_W-1:0] a,
                                                     logic [STAMP_W-1:0] b);
        logic [STAMP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAMP_W] ? '1 : s[STAMP_W-1:0];
    endfunction

    // Works out the compute instant for one frame, files it into its slot and
    // returns the result beat the core must produce for it.
    function automatic result_beat_t align_frame(frame_beat_t f);
        result_beat_t       r;
        logic [STAT_W-1:0]  st;
        logic [STAMP_W-1:0] cyc, ofs, quo, rem, prod, base, thresh;
        logic               rel;
        int                 slot;
        st  = ST_RXERR;
        cyc = (cyc_len == '0) ? 64'd1 : {32'd0, cyc_len};   // zero cycle acts as 1
        ofs = {32'd0, cmp_ofs};
        if (f.frame_ok) begin
            quo  = f.tx_stamp / cyc;
            rem  = f.tx_stamp % cyc;
            prod = quo * cyc;
            base = add_clamp(prod, ofs);
            if (base >= f.now_ns) begin
                sched_at = base;
                st = ST_WAIT;
            end else if (ofs <= rem) begin
                // instant of this cycle already past: roll to the next one
                sched_at = add_clamp(add_clamp(prod, cyc), ofs);
                st = ST_WAIT;
            end else begin
                late_drops = late_drops + 1'b1;
                st = ST_DROP;
            end
            if (st == ST_WAIT) begin
                // unmatched ids land in slot 0; with duplicates the last match wins
                slot = 0;
                for (int i = 0; i < STREAMS && i < NUM_IDS; i++)
                    if (slot_ids[i] == f.seq_id) slot = i;
                held_stamp[slot] = f.tx_stamp;
                held_pkt[slot]   = f.pkt_id;
                thresh = (sched_at >= cyc) ? sched_at - cyc : '0;
                rel       = (held_stamp[0] != '0);
                low_stamp = held_stamp[0];
                high_pkt  = held_pkt[0];
                for (int i = 0; i < STREAMS; i++) begin
                    if (held_stamp[i] < thresh)    rel = 1'b0;
                    if (held_stamp[i] < low_stamp) low_stamp = held_stamp[i];
                    if (held_pkt[i] > high_pkt)    high_pkt = held_pkt[i];
                end
                if (rel) st = ST_RELEASE;
            end
        end
        r.status        = st;
        r.compute_at    = sched_at;
        r.release_stamp = low_stamp;
        r.release_pkt   = high_pkt;
        r.drop_count    = late_drops;
        return r;
    endfunction

    function automatic void check_field(string name, logic [STAMP_W-1:0] want,
                                        logic [STAMP_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sampled at the rising edge. The result beat of the previous
    // frame and the next frame beat can share an edge, so the result is
    // checked before the new frame is predicted.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        result_beat_t want;
        if (!rst_n) begin
            took <= 1'b0;
        end else begin
            if (result_valid) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected, actual %h",
                             $time, result);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", STAMP_W'(want.status), STAMP_W'(result.status));
                    check_field("compute_at", want.compute_at, result.compute_at);
                    check_field("release_stamp", want.release_stamp,
                                result.release_stamp);
                    check_field("release_pkt", STAMP_W'(want.release_pkt),
                                STAMP_W'(result.release_pkt));
                    check_field("drop_count", STAMP_W'(want.drop_count),
                                STAMP_W'(result.drop_count));
                end
            end
            if (cfg_we) begin
                case (cfg_idx)
                    REG_CYCLE_TIME:     cyc_len = cfg_data[CYC_W-1:0];
                    REG_COMPUTE_OFFSET: cmp_ofs = cfg_data[CYC_W-1:0];
                    REG_STREAM_ID_0:    slot_ids[0] = cfg_data[SEQ_W-1:0];
                    REG_STREAM_ID_1:    slot_ids[1] = cfg_data[SEQ_W-1:0];
                    REG_STREAM_ID_2:    slot_ids[2] = cfg_data[SEQ_W-1:0];
                    REG_STREAM_ID_3:    slot_ids[3] = cfg_data[SEQ_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                pending_results.push_back(align_frame(frame));
            took <= start && !busy;

            // watchdog: any beat or register write counts as progress
            if (result_valid || (start && !busy) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** tsn_stream_cycle_aligner_core: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: falling edge. Frames go out in bursts; between bursts a random
    // gap, from none to about two frame times, so start rises in every
    // phase of the core's busy window.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n && !(start && !took)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (frame_backlog.size() > 0) begin
                frame <= frame_backlog.pop_front();
                start <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(1, 8);
                        2:       gap_left = $urandom_range(10, 80);
                        default: gap_left = $urandom_range(80, 150);
                    endcase
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_frame(logic ok, logic [SEQ_W-1:0] seq, logic [PKT_W-1:0] pkt,
                              logic [STAMP_W-1:0] ts, logic [STAMP_W-1:0] now);
        frame_beat_t f;
        f.frame_ok = ok;
        f.seq_id   = seq;
        f.pkt_id   = pkt;
        f.tx_stamp = ts;
        f.now_ns   = now;
        frame_backlog.push_back(f);
    endtask

    // Every frame gets a result beat, so an empty expectation queue means idle.
    task automatic wait_idle();
        do @(negedge clk);
        while (frame_backlog.size() != 0 || start || pending_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic apply_setup(logic [CYC_W-1:0] cyc, logic [CYC_W-1:0] ofs,
                               logic [SEQ_W-1:0] id0, logic [SEQ_W-1:0] id1,
                               logic [SEQ_W-1:0] id2, logic [SEQ_W-1:0] id3);
        set_cycle  = cyc;
        set_offset = ofs;
        set_ids[0] = id0;
        set_ids[1] = id1;
        set_ids[2] = id2;
        set_ids[3] = id3;
        write_reg(REG_CYCLE_TIME, cyc);
        write_reg(REG_COMPUTE_OFFSET, ofs);
        write_reg(REG_STREAM_ID_0, {16'd0, id0});
        write_reg(REG_STREAM_ID_1, {16'd0, id1});
        write_reg(REG_STREAM_ID_2, {16'd0, id2});
        write_reg(REG_STREAM_ID_3, {16'd0, id3});
    endtask

    // Random traffic for the current setup. Mostly well-formed rounds: one
    // frame per stream, all stamped inside the same cycle, so slots fill and
    // releases happen. The rest is receive errors, late frames and noise.
    task automatic gen_traffic(int count);
        logic [STAMP_W-1:0] cyc, ofs, epoch, ts, now;
        logic [SEQ_W-1:0]   seq;
        int                 sent, rot;
        cyc   = (set_cycle == '0) ? 64'd1 : {32'd0, set_cycle};
        ofs   = {32'd0, set_offset};
        epoch = {$urandom, $urandom};
        epoch = epoch - epoch % cyc;
        sent  = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                7: begin    // receive error, all other fields random
                    push_frame(1'b0, SEQ_W'($urandom), $urandom, {$urandom, $urandom},
                               {$urandom, $urandom});
                    sent++;
                end
                8: begin    // noise
                    push_frame(1'b1, SEQ_W'($urandom), $urandom, {$urandom, $urandom},
                               {$urandom, $urandom});
                    sent++;
                end
                9: begin    // stale frame seen well after its cycle
                    ts  = epoch + ({$urandom, $urandom} % (ofs + 1));
                    now = epoch + cyc * 4 + ofs;
                    push_frame(1'b1, set_ids[$urandom_range(0, NUM_IDS - 1)], $urandom,
                               ts, now);
                    sent++;
                end
                default: begin
                    rot = $urandom_range(0, STREAMS - 1);
                    for (int s = 0; s < STREAMS; s++) begin
                        ts = epoch + ({$urandom, $urandom} % cyc);
                        case ($urandom_range(0, 9))
                            0, 1:    now = {$urandom, $urandom};
                            2, 3, 4: now = ts + ({$urandom, $urandom} % (cyc + 1));
                            default: now = epoch + ({$urandom, $urandom} % (ofs + 1));
                        endcase
                        // now and then a sequence id that maps to no stream
                        seq = ($urandom_range(0, 9) == 0) ? SEQ_W'($urandom)
                                                          : set_ids[(s + rot) % NUM_IDS];
                        push_frame(1'b1, seq, $urandom, ts, now);
                    end
                    sent  += STREAMS;
                    epoch += cyc * $urandom_range(1, 3);
                end
            endcase
        end
    endtask

    initial begin
        set_cycle  = CYCLE_TIME_RESET;
        set_offset = '0;
        for (int i = 0; i < NUM_IDS; i++) set_ids[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed: reset setup (1 ms cycle, offset 0, every id 0) ---
        push_frame(1'b0, 16'hFFFF, 32'hFFFF_FFFF, '1, '1);      // receive error
        push_frame(1'b1, 16'h0000, '0, '0, '0);                 // all ids match: slot 3
        push_frame(1'b1, 16'h0005, 32'hFFFF_FFFF, 64'd1500000, '0); // unmatched: slot 0
        push_frame(1'b1, 16'h0005, 32'h1, '1, '1);               // next-cycle sum clamps
        push_frame(1'b1, 16'h0000, '0, '1, '0);
        wait_idle();

        // --- directed: short cycle with an offset ---
        apply_setup(32'd1000, 32'd300, 16'd10, 16'd11, 16'd12, 16'd13);
        push_frame(1'b1, 16'd10, 32'd7, 64'd1100, 64'd2000);     // late: dropped
        push_frame(1'b1, 16'd11, 32'd8, 64'd1500, 64'd2000);     // rolls to next cycle
        push_frame(1'b1, 16'd12, 32'd9, 64'd2100, 64'd1000);
        push_frame(1'b1, 16'd13, 32'd6, 64'd2200, 64'd2300);     // now equals instant
        push_frame(1'b1, 16'd10, 32'd5, 64'd2050, 64'd0);        // all slots fresh
        push_frame(1'b1, 16'hFFFF, '0, 64'd5000, 64'd9999);      // unmatched and late
        wait_idle();

        // --- directed: zero cycle length, maximum offset, duplicate ids ---
        apply_setup(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001);
        push_frame(1'b1, 16'hFFFF, 32'hA5A5_5A5A, 64'd100, 64'd200);
        push_frame(1'b1, 16'h0001, 32'd3, 64'd100, '1);          // late
        push_frame(1'b1, 16'h0000, 32'd4, 64'hFFFF_FFFF_FFFF_FFFE, '0); // base clamps
        wait_idle();

        // --- directed: widest cycle, threshold below zero ---
        apply_setup(32'hFFFF_FFFF, 32'd5, 16'd0, 16'd1, 16'd2, 16'd3);
        push_frame(1'b1, 16'd2, 32'd1, 64'hFFFF_FFFF_FFFF_FFFE, '1);
        push_frame(1'b1, 16'd3, 32'd2, '0, '0);
        push_frame(1'b1, 16'd0, 32'd3, 64'd10, 64'd3);
        push_frame(1'b0, 16'd1, 32'd4, 64'd10, 64'd3);
        wait_idle();

        // --- random phases, one setup each ---
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: apply_setup(CYCLE_TIME_RESET, $urandom_range(0, 1000000),
                               SEQ_W'($urandom), SEQ_W'($urandom),
                               SEQ_W'($urandom), SEQ_W'($urandom));
                1: apply_setup($urandom_range(1, 5000), 32'd0,
                               SEQ_W'($urandom), SEQ_W'($urandom),
                               SEQ_W'($urandom), SEQ_W'($urandom));
                2: apply_setup(32'd0, $urandom_range(0, 3),
                               16'd7, 16'd7, SEQ_W'($urandom), SEQ_W'($urandom));
                3: apply_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               16'h0000, 16'hFFFF, SEQ_W'($urandom), SEQ_W'($urandom));
                4: apply_setup($urandom, $urandom,
                               SEQ_W'($urandom), SEQ_W'($urandom),
                               SEQ_W'($urandom), SEQ_W'($urandom));
                default: apply_setup(32'd1, 32'd0,
                                     SEQ_W'($urandom), SEQ_W'($urandom),
                                     SEQ_W'($urandom), SEQ_W'($urandom));
            endcase
            if (p == 1) set_offset = set_offset;   // offset 0: nothing is ever late
            gen_traffic(150);
            wait_idle();
        end

        repeat (80) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** tsn_stream_cycle_aligner_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never came", mismatches,
                     pending_results.size());
            $display("** tsn_stream_cycle_aligner_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
design/tsca_pkg.sv
design/tsca_remdiv.sv
design/tsn_stream_cycle_aligner_core.sv
design/tsca_checker.sv
bench/tsn_stream_cycle_aligner_core_test.sv
